>>> hdl/vn_pkg.sv
// shared widths and types for the vector normalizer
package vn_pkg;
    localparam int CompWidth = 24;
    localparam int FracBits  = 16;
    localparam int MagWidth  = CompWidth;
    localparam int SqWidth   = 2 * CompWidth;
    localparam int SumWidth  = SqWidth + 2;
    localparam int UnitBits  = FracBits + 1;
    localparam int LenWidth  = SumWidth / 2 + 1;

    typedef struct packed {
        logic signed [CompWidth-1:0] vec_x;
        logic signed [CompWidth-1:0] vec_y;
        logic signed [CompWidth-1:0] vec_z;
    } vec_req_t;

    typedef struct packed {
        logic signed [CompWidth-1:0] unit_x;
        logic signed [CompWidth-1:0] unit_y;
        logic signed [CompWidth-1:0] unit_z;
        logic [SqWidth-1:0]          square_sum;
        logic [CompWidth-1:0]        length;
        logic                        normalized_ok;
        logic                        all_zero;
    } unit_rsp_t;
endpackage

>>> hdl/vn_req_if.sv
// valid/ready channel carrying input vectors
interface vn_req_if;
    logic              valid;
    logic              ready;
    vn_pkg::vec_req_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/vn_rsp_if.sv
// valid/ready channel carrying results
interface vn_rsp_if;
    logic              valid;
    logic              ready;
    vn_pkg::unit_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/vector3_normalize.sv
// top level: 3d vector norm and normalization pipeline
//
// Usage: vectors enter on req (valid/ready), results leave on rsp. One request
// may enter every clock while rsp is not stalled; nothing depends on earlier requests.
// cfg_we/cfg_data write min_square_sum (Q16.32); write only while idle.
// Pipeline: 1 stage squares, 1 stage sums, 25 stages for the square root
// (one result bit per stage, each stage with its own remainder), 1 stage
// forms the unit targets, then 17 bits resolve each unit component, two
// stages per bit, comparing (2c-1)^2*s with 4*m^2*2^2F from running sums
// built with shifts and adds, plus one output stage.
// Throughput is one vector per clock while rsp is not stalled.
// A stall on rsp freezes the whole pipeline at once (all stages hold), so
// nothing is lost or repeated; req.ready falls with rsp.ready while the
// output register is full.
// Reset clears all valid bits and loads min_square_sum with 4295.
// The length is the root rounded to nearest; unit components round half
// away from zero and saturate to the component range.
module vector3_normalize
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vn_pkg::SqWidth-1:0]    cfg_data,
    vn_req_if.sink                        req,
    vn_rsp_if.source                      rsp
);
    localparam int CW = vn_pkg::CompWidth;
    localparam int SW = vn_pkg::SumWidth;
    localparam int RS = SW / 2;           // root steps
    localparam int UB = vn_pkg::UnitBits; // unit steps
    localparam int ST = 3 + RS + 2 * UB;  // total pipe depth before output

    logic [vn_pkg::SqWidth-1:0] thr_reg;
    logic adv;
    logic [ST-1:0] v_reg;

    assign adv = !rsp.valid || rsp.ready;
    assign req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= vn_pkg::SqWidth'(4295);
        else if (cfg_we)
            thr_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[ST-2:0], req.valid};
    end

    // stage 1: magnitudes and squares
    logic [CW-1:0] m1 [3];
    logic          n1 [3];
    logic [vn_pkg::SqWidth-1:0] q1 [3];
    logic [CW-1:0] raw1 [3];

    vn_square u_sqx (.clk, .en(adv), .comp(req.data.vec_x), .mag_reg(m1[0]),
                     .neg_reg(n1[0]), .sq_reg(q1[0]));
    vn_square u_sqy (.clk, .en(adv), .comp(req.data.vec_y), .mag_reg(m1[1]),
                     .neg_reg(n1[1]), .sq_reg(q1[1]));
    vn_square u_sqz (.clk, .en(adv), .comp(req.data.vec_z), .mag_reg(m1[2]),
                     .neg_reg(n1[2]), .sq_reg(q1[2]));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            raw1[0] <= req.data.vec_x;
            raw1[1] <= req.data.vec_y;
            raw1[2] <= req.data.vec_z;
        end
    end

    // per item side data carried down the whole pipe
    typedef struct packed {
        logic [2:0][CW-1:0] raw;
        logic [2:0][CW-1:0] mag;
        logic [2:0]         neg;
        logic [SW-1:0]      sum;
        logic               ok;
    } side_t;

    // stage 2: sum and threshold
    side_t s2_reg;
    logic [SW-1:0] sum_next;
    assign sum_next = SW'(q1[0]) + SW'(q1[1]) + SW'(q1[2]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg.raw <= {raw1[2], raw1[1], raw1[0]};
            s2_reg.mag <= {m1[2], m1[1], m1[0]};
            s2_reg.neg <= {n1[2], n1[1], n1[0]};
            s2_reg.sum <= sum_next;
            s2_reg.ok  <= (sum_next != '0) && (sum_next >= SW'(thr_reg));
        end
    end

    // square root, restoring, one result bit per stage
    side_t         rs_side [RS+1];
    logic [SW-1:0] rs_rem  [RS+1];
    logic [RS:0]   rs_res  [RS+1];

    assign rs_side[0] = s2_reg;
    assign rs_rem[0]  = s2_reg.sum;
    assign rs_res[0]  = '0;

    for (genvar k = 0; k < RS; k++)
    begin : g_root
        localparam int Sh = 2 * (RS - 1 - k);
        logic [SW+1:0] trial;
        logic          take;
        assign trial = ({2'b0, rs_res[k]} << (Sh + 2)) | ((SW + 2)'(1) << Sh);
        assign take  = {2'b0, rs_rem[k]} >= trial;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rs_side[k+1] <= rs_side[k];
                rs_rem[k+1]  <= take ? SW'({2'b0, rs_rem[k]} - trial) : rs_rem[k];
                rs_res[k+1]  <= {rs_res[k][RS-1:0], take};
            end
        end
    end

    // round: rem > res means round up
    localparam int LenW = vn_pkg::LenWidth;
    logic [LenW-1:0] len_fin;
    assign len_fin = LenW'(rs_res[RS]) +
                     LenW'(rs_rem[RS] > SW'(rs_res[RS]));

    // unit magnitude search: 2 stages per bit; for the accepted bits r the
    // pipe carries a = r*s and q = r*r*s so each trial needs shifts and adds
    localparam int TW = 2 * CW + 2 * vn_pkg::FracBits + 2;
    localparam int XW = TW + 2;
    typedef logic [2:0][UB-1:0] ures_t;
    typedef logic [2:0][XW-1:0] uacc_t;

    side_t              us_side [UB+1];
    ures_t              us_r    [UB+1];
    logic [2:0][TW-1:0] us_tgt  [UB+1];
    logic [LenW-1:0]    us_len  [UB+1];
    uacc_t              us_a    [UB+1];
    uacc_t              us_q    [UB+1];

    // target = mag^2 * 2^(2F+2) formed at root exit (one multiply per component)
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            us_side[0] <= rs_side[RS];
            us_r[0]    <= '0;
            us_len[0]  <= len_fin;
            us_a[0]    <= '0;
            us_q[0]    <= '0;
            for (int i = 0; i < 3; i++)
                us_tgt[0][i] <= TW'(rs_side[RS].mag[i] * rs_side[RS].mag[i])
                                << (2 * vn_pkg::FracBits + 2);
        end
    end

    for (genvar k = 0; k < UB; k++)
    begin : g_unit
        localparam int B = UB - 1 - k;
        side_t              a_side;
        ures_t              a_r;
        logic [2:0][TW-1:0] a_tgt;
        logic [LenW-1:0]    a_len;
        uacc_t              a_a;
        uacc_t              a_q;
        uacc_t              a_c1;
        uacc_t              a_c2;
        logic [2:0]         a_skip;

        // trial c = r + 2^B: c*s and c*c*s
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a_side <= us_side[k];
                a_r    <= us_r[k];
                a_tgt  <= us_tgt[k];
                a_len  <= us_len[k];
                a_a    <= us_a[k];
                a_q    <= us_q[k];
                for (int i = 0; i < 3; i++)
                begin
                    logic [UB:0] cand;
                    cand = {1'b0, us_r[k][i]} | ((UB + 1)'(1) << B);
                    a_skip[i] <= cand > (UB + 1)'(1 << vn_pkg::FracBits);
                    a_c1[i]   <= us_a[k][i] + (XW'(us_side[k].sum) << B);
                    a_c2[i]   <= us_q[k][i] + (us_a[k][i] << (B + 1))
                                 + (XW'(us_side[k].sum) << (2 * B));
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                us_side[k+1] <= a_side;
                us_tgt[k+1]  <= a_tgt;
                us_len[k+1]  <= a_len;
                for (int i = 0; i < 3; i++)
                begin
                    logic [XW-1:0] odd_sq;
                    logic          take;
                    // (2c-1)^2*s = 4*c*c*s - 4*c*s + s
                    odd_sq = (a_c2[i] << 2) - (a_c1[i] << 2) + XW'(a_side.sum);
                    take   = !a_skip[i] && (odd_sq <= XW'(a_tgt[i]));
                    us_r[k+1][i] <= take ? (a_r[i] | (UB'(1) << B)) : a_r[i];
                    us_a[k+1][i] <= take ? a_c1[i] : a_a[i];
                    us_q[k+1][i] <= take ? a_c2[i] : a_q[i];
                end
            end
        end
    end

    // output stage: sign, saturation, select
    localparam logic [CW-1:0] PosMax = {1'b0, {(CW-1){1'b1}}};
    vn_pkg::unit_rsp_t out_reg;
    logic [2:0][CW-1:0] u_fin;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [CW:0] m;
            m = (CW + 1)'(us_r[UB][i]);
            if (!us_side[UB].ok)
                u_fin[i] = us_side[UB].raw[i];
            else if (us_side[UB].neg[i])
                u_fin[i] = (m > (CW + 1)'(PosMax) + 1) ? ~PosMax : CW'(-m);
            else
                u_fin[i] = (m > (CW + 1)'(PosMax)) ? PosMax : CW'(m);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.valid <= 1'b0;
        else if (adv)
            rsp.valid <= v_reg[ST-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.unit_x        <= u_fin[0];
            out_reg.unit_y        <= u_fin[1];
            out_reg.unit_z        <= u_fin[2];
            out_reg.square_sum    <= vn_pkg::SqWidth'(us_side[UB].sum);
            out_reg.length        <= CW'(us_len[UB]);
            out_reg.normalized_ok <= us_side[UB].ok;
            out_reg.all_zero      <= us_side[UB].sum == '0;
        end
    end

    assign rsp.data = out_reg;
endmodule

>>> hdl/vn_square.sv
// squares a component magnitude, one register stage
module vn_square
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [vn_pkg::CompWidth-1:0]  comp,
    output logic [vn_pkg::MagWidth-1:0]          mag_reg,
    output logic                                 neg_reg,
    output logic [vn_pkg::SqWidth-1:0]           sq_reg
);
    logic [vn_pkg::MagWidth-1:0] mag_next;

    assign mag_next = comp[vn_pkg::CompWidth-1] ? vn_pkg::MagWidth'(-comp)
                                                : vn_pkg::MagWidth'(comp);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
            neg_reg <= comp[vn_pkg::CompWidth-1];
            sq_reg  <= mag_next * mag_next;
        end
    end
endmodule

>>> dv/tb.sv
// testbench for vector3_normalize: table-driven and random vectors checked by a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PipeDepth = 63;
    localparam int RandCount = 800;
    localparam int CW = vn_pkg::CompWidth;
    localparam int SQW = vn_pkg::SqWidth;
    localparam int FB = vn_pkg::FracBits;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 has_known;
        logic [SQW-1:0]       known_sum;
        logic                 known_ok;
        logic                 known_zero;
    } vec_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [SQW-1:0] cfg_data = '0;

    vn_req_if req ();
    vn_rsp_if rsp ();

    vector3_normalize uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .req      (req),
        .rsp      (rsp)
    );

    logic [SQW-1:0]            min_sum_shadow = 48'd4295;
    vn_pkg::unit_rsp_t         pending_units[$];
    int                        error_count = 0;
    int                        accepted = 0;
    bit                        stall_enable = 1'b0;
    vec_row_t                  vec_rows[$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("tb: FAIL");
        $finish;
    end

    function automatic logic [127:0] comp_mag(logic signed [CW-1:0] c);
        logic [127:0] m;
        begin
            m = c[CW-1] ? 128'((~{{104{1'b0}}, c} + 1) & 128'hFFFFFF) : 128'(c);
            return m;
        end
    endfunction

    function automatic logic [127:0] root_nearest(logic [127:0] v);
        logic [127:0] lo;
        logic [127:0] hi;
        logic [127:0] mid;
        begin
            lo = 0;
            hi = 128'd1 << 32;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) >> 1;
                if (mid * mid <= v)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            // floor root r rounds up when v - r*r exceeds r
            if (v - lo * lo > lo)
                lo = lo + 1;
            return lo;
        end
    endfunction

    function automatic logic [127:0] scaled_mag(logic [127:0] mag, logic [127:0] s);
        logic [127:0] target;
        logic [127:0] r;
        logic [127:0] cand;
        logic [127:0] odd;
        begin
            target = (mag * mag) << (2 * FB + 2);
            r = 0;
            for (int b = FB; b >= 0; b--)
            begin
                cand = r | (128'd1 << b);
                if (cand <= (128'd1 << FB))
                begin
                    odd = 2 * cand - 1;
                    if (odd * odd * s <= target)
                        r = cand;
                end
            end
            return r;
        end
    endfunction

    function automatic vn_pkg::unit_rsp_t predict_unit(vn_pkg::vec_req_t v);
        vn_pkg::unit_rsp_t u;
        logic [127:0] mags[3];
        logic [127:0] sum;
        logic signed [CW-1:0] comps[3];
        logic signed [CW-1:0] outs[3];
        logic [127:0] m;
        logic ok;
        begin
            comps[0] = v.vec_x;
            comps[1] = v.vec_y;
            comps[2] = v.vec_z;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                mags[i] = comp_mag(comps[i]);
                sum = sum + mags[i] * mags[i];
            end
            ok = (sum != 0) && (sum >= 128'(min_sum_shadow));
            for (int i = 0; i < 3; i++)
            begin
                outs[i] = comps[i];
                if (ok)
                begin
                    m = scaled_mag(mags[i], sum);
                    if (comps[i][CW-1])
                    begin
                        if (m > (128'd1 << (CW - 1)))
                            m = 128'd1 << (CW - 1);
                        outs[i] = CW'(~m + 1);
                    end
                    else
                        outs[i] = (m > (128'd1 << (CW - 1)) - 1)
                            ? CW'((128'd1 << (CW - 1)) - 1) : CW'(m);
                end
            end
            u.unit_x = outs[0];
            u.unit_y = outs[1];
            u.unit_z = outs[2];
            u.square_sum = SQW'(sum);
            u.length = CW'(root_nearest(sum));
            u.normalized_ok = ok;
            u.all_zero = (sum == 0);
            return u;
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        begin
            $display("tb: mismatch on %s: got %0h, want %0h", what, got, want);
            error_count++;
        end
    endtask

    // result checking
    always @(posedge clk)
    begin
        vn_pkg::unit_rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_units.size() == 0)
                report_mismatch("unexpected result", 64'(rsp.data.square_sum), 64'd0);
            else
            begin
                want = pending_units.pop_front();
                if (rsp.data.unit_x !== want.unit_x)
                    report_mismatch("unit_x", 64'(rsp.data.unit_x), 64'(want.unit_x));
                if (rsp.data.unit_y !== want.unit_y)
                    report_mismatch("unit_y", 64'(rsp.data.unit_y), 64'(want.unit_y));
                if (rsp.data.unit_z !== want.unit_z)
                    report_mismatch("unit_z", 64'(rsp.data.unit_z), 64'(want.unit_z));
                if (rsp.data.square_sum !== want.square_sum)
                    report_mismatch("square_sum", 64'(rsp.data.square_sum),
                        64'(want.square_sum));
                if (rsp.data.length !== want.length)
                    report_mismatch("length", 64'(rsp.data.length), 64'(want.length));
                if (rsp.data.normalized_ok !== want.normalized_ok)
                    report_mismatch("normalized_ok", 64'(rsp.data.normalized_ok),
                        64'(want.normalized_ok));
                if (rsp.data.all_zero !== want.all_zero)
                    report_mismatch("all_zero", 64'(rsp.data.all_zero), 64'(want.all_zero));
            end
        end
    end

    // receiver stalls: once enabled, ready is mostly high, else held low or random; before that it stays high
    always @(posedge clk)
    begin
        int phase;
        phase = $urandom_range(0, 63);
        if (!stall_enable)
            rsp.ready <= 1'b1;
        else if (phase < 8)
            rsp.ready <= 1'b0;
        else if (phase < 24)
            rsp.ready <= 1'($urandom_range(0, 1));
        else
            rsp.ready <= 1'b1;
    end

    // send one request, holding valid until it is taken
    task automatic send_vec(vn_pkg::vec_req_t v);
        begin
            req.valid <= 1'b1;
            req.data <= v;
            @(posedge clk);
            while (!req.ready)
                @(posedge clk);
            pending_units.push_back(predict_unit(v));
            accepted++;
        end
    endtask

    task automatic idle_cycles(int n);
        begin
            req.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_pipe();
        int guard;
        begin
            req.valid <= 1'b0;
            guard = 0;
            while (pending_units.size() != 0 && guard < 200000)
            begin
                @(posedge clk);
                guard++;
            end
            if (pending_units.size() != 0)
            begin
                report_mismatch("missing results", 64'(pending_units.size()), 64'd0);
                pending_units.delete();
            end
            repeat (PipeDepth + 8) @(posedge clk);
        end
    endtask

    task automatic write_min_sum(logic [SQW-1:0] val);
        begin
            cfg_we <= 1'b1;
            cfg_data <= val;
            @(posedge clk);
            cfg_we <= 1'b0;
            min_sum_shadow = val;
        end
    endtask

    function automatic logic signed [CW-1:0] rand_comp();
        int kind;
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0: return CW'(int'($urandom_range(0, 3)) - 2);
                1: return {1'b1, {(CW - 1){1'b0}}};
                2: return {1'b0, {(CW - 1){1'b1}}};
                3: return CW'(int'($urandom_range(0, 255)) - 128);
                default: return CW'($urandom());
            endcase
        end
    endfunction

    task automatic random_phase(int count);
        vn_pkg::vec_req_t v;
        int burst;
        begin
            while (count > 0)
            begin
                burst = $urandom_range(1, 40);
                while (burst > 0 && count > 0)
                begin
                    v.vec_x = rand_comp();
                    v.vec_y = rand_comp();
                    v.vec_z = rand_comp();
                    send_vec(v);
                    burst--;
                    count--;
                end
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 12));
            end
        end
    endtask

    function automatic vec_row_t mk_row(int x, int y, int z, logic known,
        logic [SQW-1:0] s, logic ok, logic zero);
        vec_row_t r;
        begin
            r.x = CW'(x);
            r.y = CW'(y);
            r.z = CW'(z);
            r.has_known = known;
            r.known_sum = s;
            r.known_ok = ok;
            r.known_zero = zero;
            return r;
        end
    endfunction

    initial
    begin
        vn_pkg::vec_req_t v;
        vn_pkg::unit_rsp_t u;
        req.valid = 1'b0;
        req.data = '0;

        vec_rows.push_back(mk_row(0, 0, 0, 1'b1, 48'd0, 1'b0, 1'b1));
        vec_rows.push_back(mk_row(-8388608, -8388608, -8388608, 1'b1,
            48'd211106232532992, 1'b1, 1'b0));
        vec_rows.push_back(mk_row(8388607, 8388607, 8388607, 1'b0, 48'd0, 1'b0, 1'b0));
        vec_rows.push_back(mk_row(-8388608, 0, 0, 1'b1, 48'd70368744177664, 1'b1, 1'b0));
        vec_rows.push_back(mk_row(8388607, 0, 0, 1'b0, 48'd0, 1'b0, 1'b0));
        vec_rows.push_back(mk_row(65536, 0, 0, 1'b1, 48'd4294967296, 1'b1, 1'b0));
        vec_rows.push_back(mk_row(0, -65536, 0, 1'b1, 48'd4294967296, 1'b1, 1'b0));
        vec_rows.push_back(mk_row(0, 0, 1, 1'b1, 48'd1, 1'b0, 1'b0));
        vec_rows.push_back(mk_row(-1, -1, -1, 1'b1, 48'd3, 1'b0, 1'b0));
        vec_rows.push_back(mk_row(65, 10, 3, 1'b1, 48'd4334, 1'b1, 1'b0));
        vec_rows.push_back(mk_row(65536, 65536, 65536, 1'b0, 48'd0, 1'b0, 1'b0));
        vec_rows.push_back(mk_row(-3, 4, 0, 1'b0, 48'd0, 1'b0, 1'b0));
        vec_rows.push_back(mk_row(12345, -678901, 2345678, 1'b0, 48'd0, 1'b0, 1'b0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows at the reset threshold
        foreach (vec_rows[i])
        begin
            v.vec_x = vec_rows[i].x;
            v.vec_y = vec_rows[i].y;
            v.vec_z = vec_rows[i].z;
            if (vec_rows[i].has_known)
            begin
                u = predict_unit(v);
                if (u.square_sum !== vec_rows[i].known_sum
                    || u.normalized_ok !== vec_rows[i].known_ok
                    || u.all_zero !== vec_rows[i].known_zero)
                    report_mismatch("table row", 64'(i), 64'(u.square_sum));
            end
            send_vec(v);
        end
        drain_pipe();

        // threshold zero: zero vector must still not normalize
        write_min_sum('0);
        v = '0;
        send_vec(v);
        v.vec_z = CW'(1);
        send_vec(v);
        drain_pipe();

        stall_enable = 1'b1;
        random_phase(RandCount / 4);
        drain_pipe();

        // largest threshold: no vector passes, not even the extreme corner
        write_min_sum({SQW{1'b1}});
        random_phase(RandCount / 8);
        v.vec_x = {1'b1, {(CW - 1){1'b0}}};
        v.vec_y = v.vec_x;
        v.vec_z = v.vec_x;
        send_vec(v);
        drain_pipe();

        write_min_sum(48'd211106232532992);
        send_vec(v);
        drain_pipe();

        write_min_sum(SQW'({$urandom(), $urandom()}) >> $urandom_range(0, 47));
        random_phase(RandCount / 4);
        drain_pipe();

        write_min_sum(48'd4295);
        random_phase(RandCount * 3 / 8);
        drain_pipe();

        if (error_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

>>> vector3_normalize.f
hdl/vn_pkg.sv
hdl/vn_req_if.sv
hdl/vn_rsp_if.sv
hdl/vn_square.sv
hdl/vector3_normalize.sv
dv/tb.sv
